>>> hw/rtl/elrb_pkg.sv
// Shared types and constants of the error log ring buffer.
package elrb_pkg;

  localparam int LOG_DEPTH   = 16;
  localparam int ADDR_W      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W       = $clog2(LOG_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_POST = 2'd0,
    OP_READ = 2'd1,
    OP_DUMP = 2'd2,
    OP_FIND = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  code;
    logic [7:0]  comp;
    logic [7:0]  err_st;
    logic [47:0] tstamp;
    logic [31:0] key;
  } cmd_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  code;
    logic [7:0]  comp;
    logic [7:0]  err_st;
    logic [47:0] tstamp;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hw/rtl/elrb_front.sv
// Command front end: takes a command off the ports, decodes it, hands it to the queue.
module elrb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_err_code,
  input  logic [7:0]        in_err_component,
  input  logic [7:0]        in_err_state,
  input  logic [47:0]       in_time_us,
  input  logic [31:0]       in_lookup_id,
  input  elrb_pkg::q_stat_t q_stat,
  output logic              q_push,
  output elrb_pkg::cmd_t    q_cmd
);
  import elrb_pkg::*;

  logic vld_r, vld_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept;
  op_t  op_dec;

  always_comb begin
    unique case (in_operation)
      2'd0:    op_dec = OP_POST;
      2'd1:    op_dec = OP_READ;
      2'd2:    op_dec = OP_DUMP;
      default: op_dec = OP_FIND;
    endcase
  end

  assign busy   = vld_r && q_stat.full;
  assign accept = start && !busy;
  assign q_push = vld_r && !q_stat.full;
  assign q_cmd  = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    cmd_nxt = cmd_r;
    if (accept) begin
      vld_nxt        = 1'b1;
      cmd_nxt.op     = op_dec;
      // only a post carries record fields, only a find carries a key
      cmd_nxt.code   = (op_dec == OP_POST) ? in_err_code      : '0;
      cmd_nxt.comp   = (op_dec == OP_POST) ? in_err_component : '0;
      cmd_nxt.err_st = (op_dec == OP_POST) ? in_err_state     : '0;
      cmd_nxt.tstamp = (op_dec == OP_POST) ? in_time_us       : '0;
      cmd_nxt.key    = (op_dec == OP_FIND) ? in_lookup_id     : '0;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

>>> hw/rtl/elrb_queue.sv
// Short command queue between the front end and the executing back end.
module elrb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  elrb_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output elrb_pkg::cmd_t    pop_cmd,
  output elrb_pkg::q_stat_t stat
);
  import elrb_pkg::*;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_cmd    = slots[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/elrb_back.sv
// Back end: owns the record ring and runs post, read, dump and find commands.
module elrb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  elrb_pkg::q_stat_t q_stat,
  input  elrb_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              out_strobe,
  output logic              out_found,
  output logic [31:0]       out_rec_id,
  output logic [7:0]        out_rec_code,
  output logic [7:0]        out_rec_component,
  output logic [7:0]        out_rec_state,
  output logic [47:0]       out_rec_time,
  output logic [4:0]        out_stored_count,
  output logic              out_last
);
  import elrb_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } bk_state_t;

  localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(LOG_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(LOG_DEPTH - 1);

  rec_t              mem [LOG_DEPTH];

  bk_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0] ws_r, ws_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [31:0]       next_id_r, next_id_nxt;
  op_t               op_r, op_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_last_r, rd_last_nxt;
  rec_t              rd_rec_r;

  logic              o_strobe_r, o_strobe_nxt;
  logic              o_found_r, o_found_nxt;
  rec_t              o_rec_r, o_rec_nxt;
  logic [CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic              o_last_r, o_last_nxt;

  logic              mem_we;
  logic              issue;
  logic              done;
  rec_t              wr_rec;
  logic [ADDR_W-1:0] newest;
  logic [ADDR_W-1:0] ws_inc;
  logic [ADDR_W-1:0] addr_dec;

  assign newest   = (ws_r == '0) ? LAST_SLOT : ws_r - 1'b1;
  assign ws_inc   = (ws_r == LAST_SLOT) ? '0 : ws_r + 1'b1;
  assign addr_dec = (addr_r == '0) ? LAST_SLOT : addr_r - 1'b1;

  assign wr_rec.id     = next_id_r;
  assign wr_rec.code   = q_cmd.code;
  assign wr_rec.comp   = q_cmd.comp;
  assign wr_rec.err_st = q_cmd.err_st;
  assign wr_rec.tstamp = q_cmd.tstamp;

  always_comb begin
    state_nxt    = state_r;
    ws_nxt       = ws_r;
    fill_nxt     = fill_r;
    next_id_nxt  = next_id_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    addr_nxt     = addr_r;
    cnt_nxt      = cnt_r;
    total_nxt    = total_r;
    rd_vld_nxt   = 1'b0;
    rd_last_nxt  = 1'b0;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    issue        = 1'b0;
    done         = 1'b0;
    o_strobe_nxt = 1'b0;
    o_found_nxt  = 1'b0;
    o_rec_nxt    = '0;
    o_cnt_nxt    = fill_r;
    o_last_nxt   = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_POST) begin
            mem_we      = 1'b1;
            next_id_nxt = next_id_r + 1'b1;
            ws_nxt      = ws_inc;
            if (fill_r != DEPTH_C) begin
              fill_nxt = fill_r + 1'b1;
            end
            o_strobe_nxt = 1'b1;
            o_found_nxt  = 1'b1;
            o_rec_nxt    = wr_rec;
            o_cnt_nxt    = fill_nxt;
            o_last_nxt   = 1'b1;
          end else if (fill_r == '0) begin
            o_strobe_nxt = 1'b1;
            o_last_nxt   = 1'b1;
          end else begin
            state_nxt = BK_RUN;
            op_nxt    = q_cmd.op;
            key_nxt   = q_cmd.key;
            cnt_nxt   = '0;
            addr_nxt  = (q_cmd.op == OP_FIND) ? '0 : newest;
            total_nxt = (q_cmd.op == OP_READ) ? CNT_W'(1) : fill_r;
          end
        end
      end
      BK_RUN: begin
        // reads are issued one per cycle; data comes back in the cycle after
        issue = (cnt_r != total_r);
        if (issue) begin
          cnt_nxt     = cnt_r + 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = ((cnt_r + 1'b1) == total_r);
          addr_nxt    = (op_r == OP_FIND) ? addr_r + 1'b1 : addr_dec;
        end
        if (rd_vld_r) begin
          if (op_r == OP_FIND) begin
            if (rd_rec_r.id == key_r) begin
              o_strobe_nxt = 1'b1;
              o_found_nxt  = 1'b1;
              o_rec_nxt    = rd_rec_r;
              o_last_nxt   = 1'b1;
              done         = 1'b1;
            end else if (rd_last_r) begin
              o_strobe_nxt = 1'b1;
              o_last_nxt   = 1'b1;
              done         = 1'b1;
            end
          end else begin
            o_strobe_nxt = 1'b1;
            o_found_nxt  = 1'b1;
            o_rec_nxt    = rd_rec_r;
            o_last_nxt   = rd_last_r;
            done         = rd_last_r;
          end
        end
        if (done) begin
          // drop any read still in flight after an early hit
          state_nxt  = BK_IDLE;
          rd_vld_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      ws_r       <= '0;
      fill_r     <= '0;
      next_id_r  <= '0;
      rd_vld_r   <= 1'b0;
      o_strobe_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ws_r       <= ws_nxt;
      fill_r     <= fill_nxt;
      next_id_r  <= next_id_nxt;
      rd_vld_r   <= rd_vld_nxt;
      o_strobe_r <= o_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    addr_r    <= addr_nxt;
    cnt_r     <= cnt_nxt;
    total_r   <= total_nxt;
    rd_last_r <= rd_last_nxt;
    o_found_r <= o_found_nxt;
    o_rec_r   <= o_rec_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_last_r  <= o_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ws_r] <= wr_rec;
    end
    if (issue) begin
      rd_rec_r <= mem[addr_r];
    end
  end

  assign out_strobe        = o_strobe_r;
  assign out_found         = o_found_r;
  assign out_rec_id        = o_rec_r.id;
  assign out_rec_code      = o_rec_r.code;
  assign out_rec_component = o_rec_r.comp;
  assign out_rec_state     = o_rec_r.err_st;
  assign out_rec_time      = o_rec_r.tstamp;
  assign out_stored_count  = 5'(o_cnt_r);
  assign out_last          = o_last_r;

endmodule

>>> hw/rtl/error_log_ring_buffer.sv
// Top level of the error log ring buffer: front end, command queue and back end.
// Commands enter on the in_ ports: a transaction is taken at a clock edge where
// start is high and busy is low. in_operation selects post, read newest, dump
// (newest to oldest) or find by id. A post stores a record, assigns the next id
// and returns it; the ring keeps the newest LOG_DEPTH records.
// Results leave on the out_ ports, each valid for exactly one cycle while
// out_strobe is high; out_last marks the final result of a command. The
// receiver cannot stall, so results are never held back.
// On the way to the out_ ports, a post or any command on an empty log passes the
// front stage, the queue to the back end and the output register. Read, dump and
// find also pass entering the scan and the registered ring read. A dump streams
// one record per cycle; a find reads one slot per cycle from slot 0 up, through
// the single read port of the ring. Commands can be taken while the back end
// works until the two-entry queue and the front stage are full, which raises
// busy.
// Reset clears the ring pointer, fill count and id counter; the ring contents
// need no clearing since only written slots are ever read.
module error_log_ring_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_err_code,
  input  logic [7:0]  in_err_component,
  input  logic [7:0]  in_err_state,
  input  logic [47:0] in_time_us,
  input  logic [31:0] in_lookup_id,
  output logic        out_strobe,
  output logic        out_found,
  output logic [31:0] out_rec_id,
  output logic [7:0]  out_rec_code,
  output logic [7:0]  out_rec_component,
  output logic [7:0]  out_rec_state,
  output logic [47:0] out_rec_time,
  output logic [4:0]  out_stored_count,
  output logic        out_last
);
  import elrb_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;

  elrb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_err_code      (in_err_code),
    .in_err_component (in_err_component),
    .in_err_state     (in_err_state),
    .in_time_us       (in_time_us),
    .in_lookup_id     (in_lookup_id),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  elrb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  elrb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_cmd             (pop_cmd),
    .q_pop             (q_pop),
    .out_strobe        (out_strobe),
    .out_found         (out_found),
    .out_rec_id        (out_rec_id),
    .out_rec_code      (out_rec_code),
    .out_rec_component (out_rec_component),
    .out_rec_state     (out_rec_state),
    .out_rec_time      (out_rec_time),
    .out_stored_count  (out_stored_count),
    .out_last          (out_last)
  );

`ifndef ASSERT_OFF
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> (out_last && out_rec_id == 32'd0 &&
                                    out_rec_time == 48'd0))
    else $error("miss result not final or carries record data");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_stored_count <= 5'(LOG_DEPTH)))
    else $error("stored count out of range");
`endif

endmodule

>>> test/error_log_ring_buffer_checker.sv
// Checker for the error log ring buffer: tracks the log, predicts each reply and compares.
`timescale 1ns / 1ps

module error_log_ring_buffer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_err_code,
  input  logic [7:0]  in_err_component,
  input  logic [7:0]  in_err_state,
  input  logic [47:0] in_time_us,
  input  logic [31:0] in_lookup_id,
  input  logic        out_strobe,
  input  logic        out_found,
  input  logic [31:0] out_rec_id,
  input  logic [7:0]  out_rec_code,
  input  logic [7:0]  out_rec_component,
  input  logic [7:0]  out_rec_state,
  input  logic [47:0] out_rec_time,
  input  logic [4:0]  out_stored_count,
  input  logic        out_last,
  output int          fail_count,
  output int          waiting_count
);
  import elrb_pkg::*;

  typedef struct packed {
    logic             found;
    rec_t             rec;
    logic [CNT_W-1:0] count;
    logic             last;
  } log_reply_t;

  rec_t              ring [LOG_DEPTH];
  logic [ADDR_W-1:0] head_slot;
  logic [CNT_W-1:0]  held;
  logic [31:0]       id_ctr;
  log_reply_t        due_replies [$];
  int                fails = 0;

  // record fields read as zero whenever nothing valid is returned
  function automatic log_reply_t reply_of(input bit hit, input rec_t r, input bit fin);
    log_reply_t rp;
    rp.found = hit;
    rp.rec   = hit ? r : '0;
    rp.count = held;
    rp.last  = fin;
    return rp;
  endfunction

  task automatic log_command(input op_t op, input rec_t post_rec, input logic [31:0] key);
    logic [ADDR_W-1:0] slot;
    bit                hit;
    slot = head_slot - 1'b1;
    hit  = 1'b0;
    case (op)
      OP_POST: begin
        post_rec.id     = id_ctr;
        ring[head_slot] = post_rec;
        id_ctr          = id_ctr + 1;
        head_slot       = head_slot + 1'b1;
        if (held < LOG_DEPTH) held = held + 1'b1;
        due_replies.push_back(reply_of(1'b1, post_rec, 1'b1));
      end
      OP_READ: begin
        due_replies.push_back(reply_of(held != 0, ring[slot], 1'b1));
      end
      OP_DUMP: begin
        if (held == 0) begin
          due_replies.push_back(reply_of(1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < held; i++) begin
            due_replies.push_back(reply_of(1'b1, ring[slot], i == held - 1));
            slot = slot - 1'b1;
          end
        end
      end
      OP_FIND: begin
        // first match from slot 0 up, written slots only
        for (int i = 0; i < held; i++) begin
          if (!hit && ring[i].id == key) begin
            hit = 1'b1;
            due_replies.push_back(reply_of(1'b1, ring[i], 1'b1));
          end
        end
        if (!hit) due_replies.push_back(reply_of(1'b0, '0, 1'b1));
      end
      default: ;
    endcase
  endtask

  function automatic bit field_ok(input string fname, input logic [63:0] want,
                                  input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic check_reply(input log_reply_t got);
    log_reply_t want;
    bit         ok;
    if (due_replies.size() == 0) begin
      $display("%0t: unexpected result: found %0b id %0h last %0b",
               $time, got.found, got.rec.id, got.last);
      fails++;
      return;
    end
    want = due_replies.pop_front();
    ok = 1'b1;
    ok &= field_ok("found", want.found, got.found);
    ok &= field_ok("rec_id", want.rec.id, got.rec.id);
    ok &= field_ok("rec_code", want.rec.code, got.rec.code);
    ok &= field_ok("rec_component", want.rec.comp, got.rec.comp);
    ok &= field_ok("rec_state", want.rec.err_st, got.rec.err_st);
    ok &= field_ok("rec_time", want.rec.tstamp, got.rec.tstamp);
    ok &= field_ok("stored_count", want.count, got.count);
    ok &= field_ok("last", want.last, got.last);
    if (!ok) fails++;
  endtask

  always @(posedge clk) begin
    log_reply_t seen;
    rec_t       posted;
    if (!rst_n) begin
      head_slot = '0;
      held      = '0;
      id_ctr    = '0;
      due_replies.delete();
    end else begin
      if (out_strobe) begin
        seen.found      = out_found;
        seen.rec.id     = out_rec_id;
        seen.rec.code   = out_rec_code;
        seen.rec.comp   = out_rec_component;
        seen.rec.err_st = out_rec_state;
        seen.rec.tstamp = out_rec_time;
        seen.count      = out_stored_count;
        seen.last       = out_last;
        check_reply(seen);
      end
      if (start && !busy) begin
        posted.id     = '0;
        posted.code   = in_err_code;
        posted.comp   = in_err_component;
        posted.err_st = in_err_state;
        posted.tstamp = in_time_us;
        log_command(op_t'(in_operation), posted, in_lookup_id);
      end
    end
    fail_count    <= fails;
    waiting_count <= due_replies.size();
  end

endmodule

>>> test/error_log_ring_buffer_tb.sv
// Testbench top for the error log ring buffer: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module error_log_ring_buffer_tb;
  import elrb_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_TAIL   = 60;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [7:0]  in_err_code;
  logic [7:0]  in_err_component;
  logic [7:0]  in_err_state;
  logic [47:0] in_time_us;
  logic [31:0] in_lookup_id;
  logic        out_strobe;
  logic        out_found;
  logic [31:0] out_rec_id;
  logic [7:0]  out_rec_code;
  logic [7:0]  out_rec_component;
  logic [7:0]  out_rec_state;
  logic [47:0] out_rec_time;
  logic [4:0]  out_stored_count;
  logic        out_last;

  int          fail_count;
  int          waiting_count;
  int          cycles = 0;
  int          gap_pct = 0;
  logic [31:0] posts_sent = '0;

  error_log_ring_buffer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_err_code       (in_err_code),
    .in_err_component  (in_err_component),
    .in_err_state      (in_err_state),
    .in_time_us        (in_time_us),
    .in_lookup_id      (in_lookup_id),
    .out_strobe        (out_strobe),
    .out_found         (out_found),
    .out_rec_id        (out_rec_id),
    .out_rec_code      (out_rec_code),
    .out_rec_component (out_rec_component),
    .out_rec_state     (out_rec_state),
    .out_rec_time      (out_rec_time),
    .out_stored_count  (out_stored_count),
    .out_last          (out_last)
  );

  error_log_ring_buffer_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_err_code       (in_err_code),
    .in_err_component  (in_err_component),
    .in_err_state      (in_err_state),
    .in_time_us        (in_time_us),
    .in_lookup_id      (in_lookup_id),
    .out_strobe        (out_strobe),
    .out_found         (out_found),
    .out_rec_id        (out_rec_id),
    .out_rec_code      (out_rec_code),
    .out_rec_component (out_rec_component),
    .out_rec_state     (out_rec_state),
    .out_rec_time      (out_rec_time),
    .out_stored_count  (out_stored_count),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .waiting_count     (waiting_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // start stays high after acceptance unless a gap follows
  task automatic issue_cmd(input op_t op, input logic [7:0] code, input logic [7:0] comp,
                           input logic [7:0] st, input logic [47:0] t,
                           input logic [31:0] key);
    start            <= 1'b1;
    in_operation     <= op;
    in_err_code      <= code;
    in_err_component <= comp;
    in_err_state     <= st;
    in_time_us       <= t;
    in_lookup_id     <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_POST) posts_sent++;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start        <= 1'b0;
      in_operation <= 2'($urandom);
      in_lookup_id <= $urandom;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    int          pick;
    logic [63:0] t_rand;
    logic [31:0] key;

    rst_n            = 1'b0;
    start            = 1'b0;
    in_operation     = OP_POST;
    in_err_code      = '0;
    in_err_component = '0;
    in_err_state     = '0;
    in_time_us       = '0;
    in_lookup_id     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty log: read, dump and find all miss
    gap_pct = 30;
    issue_cmd(OP_READ, 8'hFF, 8'hFF, 8'hFF, '1, '1);
    issue_cmd(OP_DUMP, 8'h00, 8'h00, 8'h00, '0, '0);
    issue_cmd(OP_FIND, 8'h00, 8'h00, 8'h00, '0, 32'h0);
    issue_cmd(OP_FIND, 8'h00, 8'h00, 8'h00, '0, 32'hFFFF_FFFF);
    // field extremes
    issue_cmd(OP_POST, 8'h00, 8'h00, 8'h00, 48'h0, 32'hFFFF_FFFF);
    issue_cmd(OP_POST, 8'hFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'h0);
    issue_cmd(OP_READ, 8'h00, 8'h00, 8'h00, '0, '0);
    issue_cmd(OP_DUMP, 8'h00, 8'h00, 8'h00, '0, '0);
    issue_cmd(OP_FIND, 8'h00, 8'h00, 8'h00, '0, 32'd0);
    issue_cmd(OP_FIND, 8'h00, 8'h00, 8'h00, '0, 32'd1);
    issue_cmd(OP_FIND, 8'h00, 8'h00, 8'h00, '0, 32'd2);
    issue_cmd(OP_FIND, 8'h00, 8'h00, 8'h00, '0, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) begin
      t_rand = {$urandom, $urandom};
      issue_cmd(OP_POST, 8'($urandom), 8'($urandom), 8'($urandom), t_rand[47:0],
                $urandom);
    end
    issue_cmd(OP_DUMP, 8'h00, 8'h00, 8'h00, '0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      if (n >= RANDOM_ITEMS - QUIET_TAIL) gap_pct = 0;
      t_rand = {$urandom, $urandom};
      pick   = $urandom_range(99);
      if (pick < 35) begin
        issue_cmd(OP_POST, 8'($urandom), 8'($urandom), 8'($urandom), t_rand[47:0],
                  $urandom);
      end else if (pick < 50) begin
        issue_cmd(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), t_rand[47:0],
                  $urandom);
      end else if (pick < 62) begin
        issue_cmd(OP_DUMP, 8'($urandom), 8'($urandom), 8'($urandom), t_rand[47:0],
                  $urandom);
      end else begin
        // recent ids (some overwritten), the next id, or anything
        case ($urandom_range(3))
          0, 1:    key = posts_sent - 1 - $urandom_range(0, 20);
          2:       key = posts_sent;
          default: key = $urandom;
        endcase
        issue_cmd(OP_FIND, 8'($urandom), 8'($urandom), 8'($urandom), t_rand[47:0], key);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (LOG_DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && waiting_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
